>>> hdl/assert_macros.svh
// Assertion macros for the checker file.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define FFCA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

`define FFCA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ffca_pkg.sv
// Shared constants, types and command codes of the first-fit chunk allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package ffca_pkg;

  localparam int GRANULE_COUNT = 1024;
  localparam int ADDR_W = $clog2(GRANULE_COUNT);
  localparam int LEN_W = $clog2(GRANULE_COUNT + 1);
  localparam int SIZE_W = 11;
  localparam int OFF_W = 10;
  localparam int STAT_W = 2;
  localparam int SUM_W = ((LEN_W > SIZE_W) ? LEN_W : SIZE_W) + 1;
  localparam int ENT_W = LEN_W + 2;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FIT = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd3;

  typedef logic [1:0] rd_src_t;
  localparam rd_src_t RD_IN_OFF = 2'd0;
  localparam rd_src_t RD_ZERO = 2'd1;
  localparam rd_src_t RD_WALK = 2'd2;
  localparam rd_src_t RD_NXT = 2'd3;

  typedef logic [2:0] wr_op_t;
  localparam wr_op_t WR_NONE = 3'd0;
  localparam wr_op_t WR_CLR = 3'd1;
  localparam wr_op_t WR_ALLOC = 3'd2;
  localparam wr_op_t WR_SPLIT = 3'd3;
  localparam wr_op_t WR_KILL = 3'd4;
  localparam wr_op_t WR_FREE = 3'd5;

  typedef struct packed {
    logic head;
    logic in_use;
    logic [LEN_W-1:0] len;
  } ent_t;

  typedef struct packed {
    logic accept;
    logic rd_en;
    rd_src_t rd_src;
    wr_op_t wr_op;
    logic walk;
    logic grab;
    logic merge_add;
    logic set_res;
    logic [STAT_W-1:0] res_code;
    logic res_pos;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_free;
    logic in_zero;
    logic out_free;
    logic walk_stop;
    logic fit;
    logic split;
    logic walk_over;
    logic free_bad;
    logic has_nxt;
    logic merge;
  } sts_t;

endpackage

>>> hdl/ffca_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; width and depth are parameters.
`timescale 1ns / 1ps

module ffca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/ffca_datapath.sv
// Datapath of the chunk allocator: chunk table RAM, walk and free arithmetic, result registers.
// Depends on ffca_pkg and ffca_ram; driven by commands from ffca_ctrl.
`timescale 1ns / 1ps

module ffca_datapath import ffca_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              in_mode,
  input  logic [SIZE_W-1:0] in_req_size,
  input  logic [OFF_W-1:0]  in_free_offset,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OFF_W-1:0]  out_chunk_start,
  output logic [STAT_W-1:0] out_status
);

  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [SIZE_W-1:0] size_r;
  logic [OFF_W-1:0]  off_r;
  logic [ADDR_W-1:0] pos_r;
  logic [LEN_W-1:0]  len_r;
  logic [ADDR_W-1:0] nxt_r;
  logic [ADDR_W-1:0] split_addr_r;
  logic [LEN_W-1:0]  split_len_r;
  logic [OFF_W-1:0]  res_start_r;
  logic [STAT_W-1:0] res_status_r;
  logic              out_valid_r;
  logic [OFF_W-1:0]  out_chunk_start_r;
  logic [STAT_W-1:0] out_status_r;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  ent_t              wr_ent;
  logic [ADDR_W-1:0] rd_addr;
  logic [ENT_W-1:0]  rd_data;
  ent_t              rd_ent;
  logic [SUM_W-1:0]  walk_sum;
  logic [SUM_W-1:0]  fnxt_sum;
  logic [SUM_W-1:0]  split_sum;

  assign rd_ent = ent_t'(rd_data);
  assign walk_sum = SUM_W'(pos_r) + SUM_W'(rd_ent.len);
  assign fnxt_sum = SUM_W'(off_r) + SUM_W'(rd_ent.len);
  assign split_sum = SUM_W'(pos_r) + SUM_W'(size_r);
  assign clr_nxt = clr_r + ADDR_W'(1);

  always_comb begin
    rd_addr = '0;
    case (cmd.rd_src)
      RD_IN_OFF: rd_addr = ADDR_W'(in_free_offset);
      RD_ZERO:   rd_addr = '0;
      RD_WALK:   rd_addr = ADDR_W'(walk_sum);
      RD_NXT:    rd_addr = ADDR_W'(fnxt_sum);
      default:   rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = '0;
    wr_ent = '0;
    case (cmd.wr_op)
      WR_CLR: begin
        wr_en = 1'b1;
        wr_addr = clr_r;
        if (clr_r == '0) begin
          wr_ent = '{head: 1'b1, in_use: 1'b0, len: LEN_W'(GRANULE_COUNT)};
        end
      end
      WR_ALLOC: begin
        wr_en = 1'b1;
        wr_addr = pos_r;
        wr_ent = '{head: 1'b1, in_use: 1'b1, len: LEN_W'(size_r)};
      end
      WR_SPLIT: begin
        wr_en = 1'b1;
        wr_addr = split_addr_r;
        wr_ent = '{head: 1'b1, in_use: 1'b0, len: split_len_r};
      end
      WR_KILL: begin
        wr_en = 1'b1;
        wr_addr = nxt_r;
      end
      WR_FREE: begin
        wr_en = 1'b1;
        wr_addr = ADDR_W'(off_r);
        wr_ent = '{head: 1'b1, in_use: 1'b0, len: len_r};
      end
      default: wr_en = 1'b0;
    endcase
  end

  ffca_ram #(
    .WIDTH(ENT_W),
    .DEPTH(GRANULE_COUNT)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_ent),
    .rd_en  (cmd.rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.wr_op == WR_CLR) begin
        clr_r <= clr_nxt;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      size_r <= in_req_size;
      off_r <= in_free_offset;
      pos_r <= '0;
    end
    if (cmd.walk) begin
      pos_r <= ADDR_W'(walk_sum);
    end
    if (cmd.wr_op == WR_ALLOC) begin
      split_addr_r <= ADDR_W'(split_sum);
      split_len_r <= rd_ent.len - LEN_W'(size_r);
    end
    if (cmd.grab) begin
      len_r <= rd_ent.len;
      nxt_r <= ADDR_W'(fnxt_sum);
    end
    if (cmd.merge_add) begin
      len_r <= len_r + rd_ent.len;
    end
    if (cmd.set_res) begin
      res_status_r <= cmd.res_code;
      res_start_r <= cmd.res_pos ? OFF_W'(pos_r) : '0;
    end
    if (cmd.load_out) begin
      out_chunk_start_r <= res_start_r;
      out_status_r <= res_status_r;
    end
  end

  always_comb begin
    sts.clr_last = (clr_r == ADDR_W'(GRANULE_COUNT - 1));
    sts.in_free = in_mode;
    sts.in_zero = (in_req_size == '0);
    sts.out_free = !out_valid_r || !out_stall;
    sts.walk_stop = !rd_ent.head || (rd_ent.len == '0);
    sts.fit = !rd_ent.in_use && (SUM_W'(rd_ent.len) >= SUM_W'(size_r));
    sts.split = sts.fit && (SUM_W'(rd_ent.len) != SUM_W'(size_r)) &&
                (split_sum < SUM_W'(GRANULE_COUNT));
    sts.walk_over = (walk_sum >= SUM_W'(GRANULE_COUNT));
    sts.free_bad = (SUM_W'(off_r) >= SUM_W'(GRANULE_COUNT)) || !rd_ent.head ||
                   !rd_ent.in_use;
    sts.has_nxt = (fnxt_sum < SUM_W'(GRANULE_COUNT));
    sts.merge = rd_ent.head && !rd_ent.in_use;
  end

  assign out_valid = out_valid_r;
  assign out_chunk_start = out_chunk_start_r;
  assign out_status = out_status_r;

endmodule

>>> hdl/ffca_ctrl.sv
// Controller state machine of the chunk allocator: clearing pass, chunk walk and free sequence.
// Depends on ffca_pkg; issues commands to ffca_datapath and reads its status.
`timescale 1ns / 1ps

module ffca_ctrl import ffca_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_SPLIT = 3'd3;
  localparam logic [2:0] S_FHEAD = 3'd4;
  localparam logic [2:0] S_FNXT = 3'd5;
  localparam logic [2:0] S_FWR = 3'd6;
  localparam logic [2:0] S_FIN = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.rd_src = RD_ZERO;
    cmd.wr_op = WR_NONE;
    cmd.res_code = ST_OK;
    case (state_r)
      S_CLEAR: begin
        cmd.wr_op = WR_CLR;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.in_free) begin
            cmd.rd_en = 1'b1;
            cmd.rd_src = RD_IN_OFF;
            state_nxt = S_FHEAD;
          end else if (sts.in_zero) begin
            cmd.set_res = 1'b1;
            cmd.res_code = ST_ZERO;
            state_nxt = S_FIN;
          end else begin
            cmd.rd_en = 1'b1;
            cmd.rd_src = RD_ZERO;
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (sts.walk_stop) begin
          cmd.set_res = 1'b1;
          cmd.res_code = ST_NO_FIT;
          state_nxt = S_FIN;
        end else if (sts.fit) begin
          cmd.wr_op = WR_ALLOC;
          cmd.set_res = 1'b1;
          cmd.res_code = ST_OK;
          cmd.res_pos = 1'b1;
          state_nxt = sts.split ? S_SPLIT : S_FIN;
        end else if (sts.walk_over) begin
          cmd.set_res = 1'b1;
          cmd.res_code = ST_NO_FIT;
          state_nxt = S_FIN;
        end else begin
          cmd.walk = 1'b1;
          cmd.rd_en = 1'b1;
          cmd.rd_src = RD_WALK;
        end
      end
      S_SPLIT: begin
        cmd.wr_op = WR_SPLIT;
        state_nxt = S_FIN;
      end
      S_FHEAD: begin
        if (sts.free_bad) begin
          cmd.set_res = 1'b1;
          cmd.res_code = ST_BAD_FREE;
          state_nxt = S_FIN;
        end else begin
          cmd.grab = 1'b1;
          if (sts.has_nxt) begin
            cmd.rd_en = 1'b1;
            cmd.rd_src = RD_NXT;
            state_nxt = S_FNXT;
          end else begin
            state_nxt = S_FWR;
          end
        end
      end
      S_FNXT: begin
        if (sts.merge) begin
          cmd.wr_op = WR_KILL;
          cmd.merge_add = 1'b1;
        end
        state_nxt = S_FWR;
      end
      S_FWR: begin
        cmd.wr_op = WR_FREE;
        cmd.set_res = 1'b1;
        cmd.res_code = ST_OK;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

>>> hdl/first_fit_chunk_allocator_core.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_mode, in_req_size, in_free_offset
// out      output     out_valid/out_stall  out_chunk_start, out_status
//
// An allocate walks chunk heads from offset 0 until one fits, then writes any split-off remainder.
// A free reads its chunk head, then the next one unless its chunk ends the area; a refused free or
// a zero-size allocate goes straight to its result. The chunk table RAM's single read port sets the
// walk at one chunk per cycle. After reset the chunk table is cleared, during which in_stall stays
// high. A new item is taken while the previous result waits on a stalled output.
// Top level of the first-fit chunk allocator; depends on ffca_pkg, ffca_ctrl and ffca_datapath.
`timescale 1ns / 1ps

module first_fit_chunk_allocator_core import ffca_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic [SIZE_W-1:0] in_req_size,
  input  logic [OFF_W-1:0]  in_free_offset,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OFF_W-1:0]  out_chunk_start,
  output logic [STAT_W-1:0] out_status
);

  cmd_t cmd;
  sts_t sts;

  ffca_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  ffca_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_mode        (in_mode),
    .in_req_size    (in_req_size),
    .in_free_offset (in_free_offset),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_chunk_start(out_chunk_start),
    .out_status     (out_status)
  );

endmodule

>>> hdl/ffca_checker.sv
// Port-level checker of the chunk allocator, bound to the top level.
// Depends on ffca_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffca_checker import ffca_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [OFF_W-1:0]  out_chunk_start,
  input logic [STAT_W-1:0] out_status
);

  logic       in_acc;
  logic       out_acc;
  logic       out_fail;
  logic [1:0] pend_r;

  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign out_fail = out_valid && (out_status != ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  `FFCA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped")
  `FFCA_ASSERT_IMP(a_fail_start, clk, rst_n, out_fail, out_chunk_start == '0, "start on failure")
  `FFCA_ASSERT_IMP(a_no_invent, clk, rst_n, out_valid, pend_r != 2'd0, "result without an item")
  `FFCA_ASSERT_IMP(a_pend_max, clk, rst_n, in_acc, pend_r < 2'd2, "too many items in flight")
  `FFCA_ASSERT_IMP(a_clear_stall, clk, rst_n, !$past(rst_n), in_stall, "item taken during clear")

endmodule

bind first_fit_chunk_allocator_core ffca_checker u_ffca_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_chunk_start(out_chunk_start),
  .out_status     (out_status)
);

>>> bench/tb_top.sv
// Testbench of the first-fit chunk allocator: directed table plus random alloc/free traffic.
// Results are checked against an in-bench model of the chunk map; depends on ffca_pkg and the core.
`timescale 1ns / 1ps

module tb_top;
  import ffca_pkg::*;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE = 1'b1;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 500;
  localparam int SETTLE_CYCLES = 1100;

  typedef struct {
    logic [OFF_W-1:0]  start;
    logic [STAT_W-1:0] status;
  } alloc_result_t;

  typedef struct {
    logic              mode;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  offset;
    bit                typed;
    logic [OFF_W-1:0]  start;
    logic [STAT_W-1:0] status;
  } request_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_mode;
  logic [SIZE_W-1:0] in_req_size;
  logic [OFF_W-1:0]  in_free_offset;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [OFF_W-1:0]  out_chunk_start;
  logic [STAT_W-1:0] out_status;

  bit               map_head [GRANULE_COUNT];
  bit               map_used [GRANULE_COUNT];
  logic [LEN_W-1:0] map_len [GRANULE_COUNT];

  alloc_result_t pending_results[$];
  request_row_t  directed_plan[$];
  int            mismatches = 0;
  int            idle_pct;
  int            stall_pct;
  int            hold_req;
  int            hold_ack = 0;
  int            hold_left = 0;
  int            quiet_cycles = 0;

  first_fit_chunk_allocator_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_req_size     (in_req_size),
    .in_free_offset  (in_free_offset),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_chunk_start (out_chunk_start),
    .out_status      (out_status)
  );

  always #10 clk = ~clk;

  function automatic void predict_request(input logic mode, input logic [SIZE_W-1:0] size,
                                          input logic [OFF_W-1:0] offset,
                                          output logic [OFF_W-1:0] start,
                                          output logic [STAT_W-1:0] status);
    int pos;
    int nxt;
    logic [LEN_W-1:0] span;
    bit done;
    start = '0;
    if (mode == MODE_ALLOC) begin
      if (size == 0) begin
        status = ST_ZERO;
      end else begin
        status = ST_NO_FIT;
        pos = 0;
        done = 1'b0;
        while (!done && pos < GRANULE_COUNT) begin
          span = map_len[pos];
          if (!map_head[pos] || span == 0) begin
            done = 1'b1;
          end else if (!map_used[pos] && span >= size) begin
            nxt = pos + int'(size);
            if (span > size && nxt < GRANULE_COUNT) begin
              map_head[nxt] = 1'b1;
              map_used[nxt] = 1'b0;
              map_len[nxt] = span - size[LEN_W-1:0];
            end
            map_used[pos] = 1'b1;
            map_len[pos] = size[LEN_W-1:0];
            start = pos[OFF_W-1:0];
            status = ST_OK;
            done = 1'b1;
          end else begin
            pos += int'(span);
          end
        end
      end
    end else begin
      status = ST_BAD_FREE;
      if (map_head[offset] && map_used[offset]) begin
        span = map_len[offset];
        nxt = int'(offset) + int'(span);
        if (nxt < GRANULE_COUNT && map_head[nxt] && !map_used[nxt]) begin
          span += map_len[nxt];
          map_head[nxt] = 1'b0;
          map_len[nxt] = '0;
        end
        map_used[offset] = 1'b0;
        map_len[offset] = span;
        status = ST_OK;
      end
    end
  endfunction

  task automatic offer_request(input logic mode, input logic [SIZE_W-1:0] size,
                               input logic [OFF_W-1:0] offset, input bit typed,
                               input logic [OFF_W-1:0] typed_start,
                               input logic [STAT_W-1:0] typed_status);
    alloc_result_t predicted;
    logic [OFF_W-1:0] start;
    logic [STAT_W-1:0] status;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_req_size <= size;
    in_free_offset <= offset;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_request(mode, size, offset, start, status);
    predicted.start = typed ? typed_start : start;
    predicted.status = typed ? typed_status : status;
    pending_results.push_back(predicted);
  endtask

  task automatic pick_request(output logic mode, output logic [SIZE_W-1:0] size,
                              output logic [OFF_W-1:0] offset);
    int roll;
    int grade;
    int live[$];
    roll = $urandom_range(99);
    size = SIZE_W'($urandom_range(2047));
    offset = OFF_W'($urandom_range(GRANULE_COUNT - 1));
    if (roll >= 50) begin
      for (int g = 0; g < GRANULE_COUNT; g++) begin
        if (map_head[g] && map_used[g]) live.push_back(g);
      end
    end
    if (roll < 50 || (roll < 90 && live.size() == 0)) begin
      mode = MODE_ALLOC;
      grade = $urandom_range(99);
      if (grade < 80) size = SIZE_W'($urandom_range(48, 1));
      else if (grade < 92) size = SIZE_W'($urandom_range(GRANULE_COUNT, 49));
      else if (grade < 96) size = '0;
      else size = SIZE_W'($urandom_range(2047, GRANULE_COUNT + 1));
    end else if (roll < 90) begin
      mode = MODE_FREE;
      offset = OFF_W'(live[$urandom_range(live.size() - 1)]);
    end else begin
      mode = MODE_FREE;
    end
  endtask

  task automatic run_phase(input int count, input int idle, input int stall, input bit hold);
    logic m;
    logic [SIZE_W-1:0] s;
    logic [OFF_W-1:0] o;
    idle_pct = idle;
    stall_pct <= stall;
    if (hold) hold_req <= hold_req + 1;
    repeat (count) begin
      pick_request(m, s, o);
      offer_request(m, s, o, 1'b0, '0, ST_OK);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    alloc_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result start %0d status %0d", $time, out_chunk_start,
                 out_status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_chunk_start !== want.start) begin
          $display("%0t: chunk_start expected %0d actual %0d", $time, want.start,
                   out_chunk_start);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          mismatches++;
        end
      end
    end
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_ALLOC;
    in_req_size = '0;
    in_free_offset = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    for (int g = 0; g < GRANULE_COUNT; g++) begin
      map_head[g] = 1'b0;
      map_used[g] = 1'b0;
      map_len[g] = '0;
    end
    map_head[0] = 1'b1;
    map_len[0] = LEN_W'(GRANULE_COUNT);

    directed_plan = '{
      '{MODE_ALLOC, 11'd0,    10'd0,    1'b1, 10'd0, ST_ZERO},
      '{MODE_ALLOC, 11'd2047, 10'd1023, 1'b1, 10'd0, ST_NO_FIT},
      '{MODE_ALLOC, 11'd1025, 10'd0,    1'b1, 10'd0, ST_NO_FIT},
      '{MODE_FREE,  11'd0,    10'd0,    1'b1, 10'd0, ST_BAD_FREE},
      '{MODE_FREE,  11'd0,    10'd1023, 1'b1, 10'd0, ST_BAD_FREE},
      '{MODE_ALLOC, 11'd1024, 10'd0,    1'b1, 10'd0, ST_OK},
      '{MODE_ALLOC, 11'd1,    10'd0,    1'b1, 10'd0, ST_NO_FIT},
      '{MODE_FREE,  11'd0,    10'd0,    1'b1, 10'd0, ST_OK},
      '{MODE_ALLOC, 11'd1,    10'd0,    1'b1, 10'd0, ST_OK},
      '{MODE_ALLOC, 11'd1022, 10'd0,    1'b0, 10'd0, ST_OK},
      '{MODE_ALLOC, 11'd1,    10'd0,    1'b0, 10'd0, ST_OK},
      '{MODE_ALLOC, 11'd1,    10'd0,    1'b0, 10'd0, ST_OK},
      '{MODE_FREE,  11'd2047, 10'd1,    1'b0, 10'd0, ST_OK},
      '{MODE_FREE,  11'd0,    10'd1,    1'b0, 10'd0, ST_OK},
      '{MODE_FREE,  11'd0,    10'd0,    1'b0, 10'd0, ST_OK},
      '{MODE_ALLOC, 11'd512,  10'd0,    1'b0, 10'd0, ST_OK},
      '{MODE_ALLOC, 11'd256,  10'd0,    1'b0, 10'd0, ST_OK},
      '{MODE_FREE,  11'd0,    10'd0,    1'b0, 10'd0, ST_OK},
      '{MODE_FREE,  11'd0,    10'd512,  1'b0, 10'd0, ST_OK},
      '{MODE_ALLOC, 11'd1000, 10'd0,    1'b0, 10'd0, ST_OK},
      '{MODE_ALLOC, 11'd511,  10'd0,    1'b0, 10'd0, ST_OK},
      '{MODE_FREE,  11'd2047, 10'd1023, 1'b0, 10'd0, ST_OK},
      '{MODE_ALLOC, 11'd2,    10'd0,    1'b0, 10'd0, ST_OK},
      '{MODE_FREE,  11'd0,    10'd700,  1'b0, 10'd0, ST_OK}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      offer_request(directed_plan[i].mode, directed_plan[i].size, directed_plan[i].offset,
                    directed_plan[i].typed, directed_plan[i].start, directed_plan[i].status);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    run_phase(400, 0, 0, 1'b0);
    run_phase(400, 71, 0, 1'b0);
    run_phase(400, 0, 71, 1'b0);
    run_phase(400, 8, 8, 1'b0);
    run_phase(330, 0, 0, 1'b1);

    stall_pct <= 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/ffca_pkg.sv
hdl/ffca_ram.sv
hdl/ffca_datapath.sv
hdl/ffca_ctrl.sv
hdl/first_fit_chunk_allocator_core.sv
hdl/ffca_checker.sv
bench/tb_top.sv
